// ===== rtl/pid_controller_timestamped_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PID_CONTROLLER_TIMESTAMPED_UNIT_DEFINES_SVH
`define PID_CONTROLLER_TIMESTAMPED_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define PIDTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pidts check failed");

// Check a consequent in the cycle after its antecedent.
`define PIDTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pidts check failed");

`endif

// ===== rtl/pidts_pkg.sv =====
`default_nettype none

package pidts_pkg;

  // Sequencer states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_MUL_SDT = 12'b0000_0000_0010,
    ST_MUL_INC = 12'b0000_0000_0100,
    ST_INT_ADD = 12'b0000_0000_1000,
    ST_MUL_P   = 12'b0000_0001_0000,
    ST_MUL_I   = 12'b0000_0010_0000,
    ST_SUM_I   = 12'b0000_0100_0000,
    ST_MUL_D   = 12'b0000_1000_0000,
    ST_ABS     = 12'b0001_0000_0000,
    ST_DIV     = 12'b0010_0000_0000,
    ST_SUM_D   = 12'b0100_0000_0000,
    ST_FIN     = 12'b1000_0000_0000
  } state_e;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_GAIN_PROP    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_INTEG   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_DERIV   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TARGET_VALUE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TICK_MULT    = 3'd4;

  localparam logic [23:0] TickMultReset = 24'h10_0000;

  // Shared adder and step counter
  localparam int unsigned AluW = 64;
  localparam int unsigned CntW = 6;

  // Last count of each iterative pass (steps minus one)
  localparam logic [CntW-1:0] LastSdt  = 6'd23;
  localparam logic [CntW-1:0] LastInc  = 6'd16;
  localparam logic [CntW-1:0] LastGain = 6'd15;
  localparam logic [CntW-1:0] LastDiv  = 6'd53;

endpackage

`default_nettype wire

// ===== rtl/pid_controller_timestamped_unit.sv =====
// Channel | Direction | Handshake             | Payload
// in      | sink      | in_valid_i/in_stall_o   | opcode, timestamp, sample
// out     | source    | out_valid_o/out_stall_i | drive, deriv_skipped, saturated
// cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Opcode 0 is taken and the block is ready again in the next cycle.
// Opcode 1 stalls the input until its result enters the output register (no
// derivative pass on zero scaled dt): one 64-bit add/sub unit runs every shift-add
// multiply (24 + 17 + 3x16 steps) and the 54-step restoring divide (derivative).
// The result sits in an output register; the next item is taken while it waits.
// Reset is asynchronous, active low, and restores gains, setpoint, time scale
// and the controller history.

`default_nettype none

module pid_controller_timestamped_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           in_opcode_i,
  input  wire logic        [31:0]             in_timestamp_i,
  input  wire logic signed [15:0]             in_sample_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [31:0]                  out_drive_o,
  output logic                                out_deriv_skipped_o,
  output logic                                out_saturated_o,
  // configuration channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pidts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [pidts_pkg::CfgDataW-1:0] cfg_data_i
);

  import pidts_pkg::*;

  state_e state_q, state_d;

  // configuration
  logic [15:0] gain_prop_q, gain_integ_q, gain_deriv_q, target_q;
  logic [23:0] tick_mult_q;

  // controller history
  logic [31:0] prev_ts_q, prev_ts_d;
  logic [16:0] prev_err_q, prev_err_d;
  logic [47:0] integ_q, integ_d;

  // work registers
  logic [AluW-1:0] acc_q, acc_d;
  logic [AluW-1:0] opa_q, opa_d;
  logic [23:0]     opb_q, opb_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            sgn_q, sgn_d;
  logic [55:0]     sdt_q, sdt_d;
  logic [AluW-1:0] sum_q, sum_d;
  logic [16:0]     err_q, err_d;
  logic            neg_q, neg_d;
  logic            skip_q, skip_d;
  logic            sat_q, sat_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_drive_q, out_drive_d;
  logic        out_skip_q, out_skip_d;
  logic        out_sat_q, out_sat_d;

  // shared adder
  logic [AluW-1:0] alu_a, alu_b, alu_res;
  logic            alu_sub;

  logic            in_acc, cfg_acc, out_free;
  logic [16:0]     err_new;
  logic [31:0]     dt_new;
  logic [17:0]     derr;
  logic [AluW-1:0] mul_acc, div_trial;
  logic            mul_last, div_q;
  logic            integ_ovf, drive_ovf;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign err_new = {target_q[15], target_q} - {in_sample_i[15], in_sample_i};
  assign dt_new  = in_timestamp_i - prev_ts_q;
  assign derr    = {err_q[16], err_q} - {prev_err_q[16], prev_err_q};

  // Select operands of the shared add/sub unit
  always_comb begin
    alu_a   = acc_q;
    alu_b   = opa_q;
    alu_sub = 1'b0;
    unique case (state_q) inside
      ST_MUL_SDT, ST_MUL_INC, ST_MUL_P, ST_MUL_I, ST_MUL_D: begin
        // the top bit of a signed multiplier carries negative weight
        alu_sub = sgn_q && mul_last;
      end
      ST_INT_ADD: begin
        alu_a = {{16{integ_q[47]}}, integ_q};
        alu_b = acc_q;
      end
      ST_SUM_I: begin
        alu_a = sum_q;
        alu_b = {{8{acc_q[63]}}, acc_q[63:8]};
      end
      ST_ABS: begin
        alu_a   = '0;
        alu_b   = acc_q;
        alu_sub = acc_q[63];
      end
      ST_DIV: begin
        alu_a   = div_trial;
        alu_b   = {8'b0, sdt_q};
        alu_sub = 1'b1;
      end
      ST_SUM_D: begin
        alu_a   = sum_q;
        alu_b   = {10'b0, opa_q[53:0]};
        alu_sub = neg_q;
      end
      default: ;
    endcase
  end

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(AluW-1){1'b0}}, alu_sub};

  assign mul_last  = (cnt_q == '0);
  assign mul_acc   = opb_q[0] ? alu_res : acc_q;
  assign div_trial = {acc_q[62:0], opa_q[53]};
  assign div_q     = !alu_res[63];
  assign integ_ovf = !((&alu_res[63:47]) || (~|alu_res[63:47]));
  assign drive_ovf = !((&sum_q[63:31]) || (~|sum_q[63:31]));

  // Sequencer and datapath next values
  always_comb begin
    state_d     = state_q;
    prev_ts_d   = prev_ts_q;
    prev_err_d  = prev_err_q;
    integ_d     = integ_q;
    acc_d       = acc_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    cnt_d       = cnt_q;
    sgn_d       = sgn_q;
    sdt_d       = sdt_q;
    sum_d       = sum_q;
    err_d       = err_q;
    neg_d       = neg_q;
    skip_d      = skip_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_drive_d = out_drive_q;
    out_skip_d  = out_skip_q;
    out_sat_d   = out_sat_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          prev_ts_d = in_timestamp_i;
          if (in_opcode_i) begin
            // start scaled dt = dt * time scale
            err_d   = err_new;
            acc_d   = '0;
            opa_d   = {32'b0, dt_new};
            opb_d   = tick_mult_q;
            cnt_d   = LastSdt;
            sgn_d   = 1'b0;
            skip_d  = 1'b0;
            sat_d   = 1'b0;
            state_d = ST_MUL_SDT;
          end
        end
      end
      ST_MUL_SDT: begin
        acc_d = mul_acc;
        opa_d = opa_q << 1;
        opb_d = opb_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (mul_last) begin
          // start integral step = error * (scaled dt >> 12)
          sdt_d   = mul_acc[55:0];
          acc_d   = '0;
          opa_d   = {20'b0, mul_acc[55:12]};
          opb_d   = {7'b0, err_q};
          cnt_d   = LastInc;
          sgn_d   = 1'b1;
          state_d = ST_MUL_INC;
        end
      end
      ST_MUL_INC: begin
        acc_d = mul_acc;
        opa_d = opa_q << 1;
        opb_d = opb_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (mul_last) begin
          state_d = ST_INT_ADD;
        end
      end
      ST_INT_ADD: begin
        // saturate the integral to 48 bits
        if (integ_ovf) begin
          integ_d = alu_res[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end else begin
          integ_d = alu_res[47:0];
        end
        sat_d   = integ_ovf;
        acc_d   = '0;
        opa_d   = {{47{err_q[16]}}, err_q};
        opb_d   = {8'b0, gain_prop_q};
        cnt_d   = LastGain;
        sgn_d   = 1'b1;
        state_d = ST_MUL_P;
      end
      ST_MUL_P: begin
        acc_d = mul_acc;
        opa_d = opa_q << 1;
        opb_d = opb_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (mul_last) begin
          sum_d   = mul_acc;
          acc_d   = '0;
          opa_d   = {{16{integ_q[47]}}, integ_q};
          opb_d   = {8'b0, gain_integ_q};
          cnt_d   = LastGain;
          state_d = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        acc_d = mul_acc;
        opa_d = opa_q << 1;
        opb_d = opb_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (mul_last) begin
          state_d = ST_SUM_I;
        end
      end
      ST_SUM_I: begin
        // add the floored integral term, then skip the derivative on zero dt
        sum_d      = alu_res;
        prev_err_d = err_q;
        if (sdt_q == '0) begin
          skip_d  = 1'b1;
          state_d = ST_FIN;
        end else begin
          acc_d   = '0;
          opa_d   = {{46{derr[17]}}, derr};
          opb_d   = {8'b0, gain_deriv_q};
          cnt_d   = LastGain;
          state_d = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        acc_d = mul_acc;
        opa_d = opa_q << 1;
        opb_d = opb_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (mul_last) begin
          state_d = ST_ABS;
        end
      end
      ST_ABS: begin
        // load |num| << 20 as the dividend
        neg_d   = acc_q[63];
        acc_d   = '0;
        opa_d   = {10'b0, alu_res[33:0], 20'b0};
        cnt_d   = LastDiv;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        acc_d = div_q ? alu_res : div_trial;
        opa_d = {10'b0, opa_q[52:0], div_q};
        cnt_d = cnt_q - 1'b1;
        if (mul_last) begin
          state_d = ST_SUM_D;
        end
      end
      ST_SUM_D: begin
        sum_d   = alu_res;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // hand the transaction to the output register when it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_drive_d = drive_ovf ? (sum_q[63] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                  : sum_q[31:0];
          out_skip_d  = skip_q;
          out_sat_d   = sat_q || drive_ovf;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control, configuration and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
      target_q     <= '0;
      tick_mult_q  <= TickMultReset;
      prev_ts_q    <= '0;
      prev_err_q   <= '0;
      integ_q      <= '0;
      cnt_q        <= '0;
      sgn_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      prev_ts_q   <= prev_ts_d;
      prev_err_q  <= prev_err_d;
      integ_q     <= integ_d;
      cnt_q       <= cnt_d;
      sgn_q       <= sgn_d;
      if (cfg_acc) begin
        unique case (cfg_index_i)
          REG_GAIN_PROP:    gain_prop_q  <= cfg_data_i[15:0];
          REG_GAIN_INTEG:   gain_integ_q <= cfg_data_i[15:0];
          REG_GAIN_DERIV:   gain_deriv_q <= cfg_data_i[15:0];
          REG_TARGET_VALUE: target_q     <= cfg_data_i[15:0];
          REG_TICK_MULT:    tick_mult_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    opa_q       <= opa_d;
    opb_q       <= opb_d;
    sdt_q       <= sdt_d;
    sum_q       <= sum_d;
    err_q       <= err_d;
    neg_q       <= neg_d;
    skip_q      <= skip_d;
    sat_q       <= sat_d;
    out_drive_q <= out_drive_d;
    out_skip_q  <= out_skip_d;
    out_sat_q   <= out_sat_d;
  end

  assign out_valid_o         = out_valid_q;
  assign out_drive_o         = out_drive_q;
  assign out_deriv_skipped_o = out_skip_q;
  assign out_saturated_o     = out_sat_q;

endmodule

`default_nettype wire

// ===== rtl/pidts_checker.sv =====
`default_nettype none

`include "pid_controller_timestamped_unit_defines.svh"

module pidts_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        in_opcode_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] out_drive_o,
  input wire logic        out_deriv_skipped_o,
  input wire logic        out_saturated_o
);

  // Hold a stalled result transaction
  `PIDTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_drive_o) && $stable(out_deriv_skipped_o) && $stable(out_saturated_o))

  // A compute transaction keeps the input busy
  `PIDTS_ASSERT_NEXT(a_busy_after_compute, in_valid_i && !in_stall_o && in_opcode_i, in_stall_o)

  // A timestamp-only transaction leaves the input ready
  `PIDTS_ASSERT_NEXT(a_ready_after_record, in_valid_i && !in_stall_o && !in_opcode_i, !in_stall_o)

  // A new result only comes out of a busy period
  `PIDTS_ASSERT_NOW(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind pid_controller_timestamped_unit pidts_checker u_pidts_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidts_pkg::*;

  // Opcodes of the input channel
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_STEP   = 1'b1;

  localparam longint IntegMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint IntegMin = -IntegMax - 1;
  localparam longint DriveMax = 64'sd2147483647;
  localparam longint DriveMin = -64'sd2147483648;

  // Cycles to let an opcode-1 pass run out before touching the registers
  localparam int SettleCycles = 160;

  typedef struct packed {
    logic               opcode;
    logic        [31:0] stamp;
    logic signed [15:0] meas;
  } pid_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               deriv_skipped;
    logic               saturated;
  } pid_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                in_opcode_i    = 1'b0;
  logic         [31:0] in_timestamp_i = '0;
  logic signed  [15:0] in_sample_i    = '0;

  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic signed  [31:0] out_drive_o;
  logic                out_deriv_skipped_o;
  logic                out_saturated_o;

  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  // Controller copy: registers and history
  logic signed [15:0] kp_q     = '0;
  logic signed [15:0] ki_q     = '0;
  logic signed [15:0] kd_q     = '0;
  logic signed [15:0] target_q = '0;
  logic        [23:0] tscale_q = TickMultReset;
  logic        [31:0] last_stamp = '0;
  longint             last_err   = 0;
  longint             integ_acc  = 0;

  pid_item_t   step_q[$];
  pid_result_t drive_expect_q[$];
  int          pending_items  = 0;
  int          mismatch_count = 0;
  logic [31:0] gen_stamp      = '0;

  pid_item_t   next_item;
  pid_result_t want;
  int          in_gap   = 0;
  int          out_hold = 0;
  bit          in_burst  = 1'b0;
  bit          out_burst = 1'b0;

  pid_controller_timestamped_unit uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_opcode_i         (in_opcode_i),
    .in_timestamp_i      (in_timestamp_i),
    .in_sample_i         (in_sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_drive_o         (out_drive_o),
    .out_deriv_skipped_o (out_deriv_skipped_o),
    .out_saturated_o     (out_saturated_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Compute the drive of one opcode-1 step and advance integral and error history
  function automatic pid_result_t pid_drive_calc(input logic [31:0] stamp,
                                                 input logic signed [15:0] meas);
    logic [31:0]     dt32;
    longint unsigned sdt, mag, quo;
    longint          err, inc, acc, p_term, i_term, d_term, num, total;
    pid_result_t     r;
    r    = '0;
    dt32 = stamp - last_stamp;
    sdt  = 64'(dt32) * 64'(tscale_q);
    err  = longint'(target_q) - longint'(meas);

    // integral on scaled dt truncated to 8 fraction bits, saturating at 48 bits
    inc = err * longint'(sdt >> 12);
    acc = integ_acc + inc;
    if (acc > IntegMax) begin
      acc = IntegMax;
      r.saturated = 1'b1;
    end
    if (acc < IntegMin) begin
      acc = IntegMin;
      r.saturated = 1'b1;
    end
    integ_acc = acc;

    p_term = kp_q * err;
    i_term = (ki_q * integ_acc) >>> 8;

    // derivative divides by scaled dt, truncated toward zero
    d_term = 0;
    if (sdt == 0) begin
      r.deriv_skipped = 1'b1;
    end else begin
      num = kd_q * (err - last_err);
      mag = (num < 0) ? -num : num;
      quo = (mag << 20) / sdt;
      d_term = (num < 0) ? -longint'(quo) : longint'(quo);
    end
    last_err = err;

    total = p_term + i_term + d_term;
    if (total > DriveMax) begin
      total = DriveMax;
      r.saturated = 1'b1;
    end
    if (total < DriveMin) begin
      total = DriveMin;
      r.saturated = 1'b1;
    end
    r.drive = total[31:0];
    return r;
  endfunction

  // Input driver: take the accepted transaction into the controller copy, then
  // present the next one after its gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        if (in_opcode_i == OP_STEP) begin
          drive_expect_q.push_back(pid_drive_calc(in_timestamp_i, in_sample_i));
        end
        last_stamp = in_timestamp_i;
        pending_items--;
        in_gap = in_burst ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (step_q.size() > 0) begin
        next_item = step_q.pop_front();
        in_valid_i     <= 1'b1;
        in_opcode_i    <= next_item.opcode;
        in_timestamp_i <= next_item.stamp;
        in_sample_i    <= next_item.meas;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor: check each accepted result, hold stall for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold = $urandom_range(0, 4);
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (drive_expect_q.size() == 0) begin
          $error("result with no step pending: drive %0d", $signed(out_drive_o));
          mismatch_count++;
        end else begin
          want = drive_expect_q.pop_front();
          if (out_drive_o !== want.drive) begin
            $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(out_drive_o));
            mismatch_count++;
          end
          if (out_deriv_skipped_o !== want.deriv_skipped) begin
            $error("deriv_skipped: expected %0b, got %0b", want.deriv_skipped,
                   out_deriv_skipped_o);
            mismatch_count++;
          end
          if (out_saturated_o !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, out_saturated_o);
            mismatch_count++;
          end
        end
        out_hold = out_burst ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      end else if (out_valid_o && out_hold > 0) begin
        out_hold--;
      end
      out_stall_i <= (out_hold > 0);
    end
  end

  // Write one register and mirror it into the controller copy
  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_GAIN_PROP:    kp_q     = val[15:0];
      REG_GAIN_INTEG:   ki_q     = val[15:0];
      REG_GAIN_DERIV:   kd_q     = val[15:0];
      REG_TARGET_VALUE: target_q = val[15:0];
      REG_TICK_MULT:    tscale_q = val;
      default: ;
    endcase
  endtask

  task automatic queue_item(input logic op, input logic [31:0] stamp,
                            input logic [15:0] meas);
    pid_item_t it;
    it.opcode = op;
    it.stamp  = stamp;
    it.meas   = meas;
    pending_items++;
    step_q.push_back(it);
    gen_stamp = stamp;
  endtask

  // Wait until every step is taken and answered, then let the block go quiet
  task automatic settle();
    while (pending_items != 0 || drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Gain or setpoint: full range, extremes or small values; upper data bits random
  function automatic logic [23:0] gain_pick();
    logic [15:0] g;
    case ($urandom_range(0, 5))
      0:       g = 16'h8000;
      1:       g = 16'h7FFF;
      2:       g = 16'($urandom);
      default: g = 16'($urandom_range(0, 1023) - 512);
    endcase
    return {8'($urandom), g};
  endfunction

  task automatic draw_setup();
    logic [23:0] ts;
    reg_write(REG_GAIN_PROP, gain_pick());
    reg_write(REG_GAIN_INTEG, gain_pick());
    reg_write(REG_GAIN_DERIV, gain_pick());
    reg_write(REG_TARGET_VALUE, gain_pick());
    case ($urandom_range(0, 7))
      0:       ts = '0;
      1:       ts = 24'hFF_FFFF;
      2:       ts = 24'($urandom_range(1, 255));
      3:       ts = 24'($urandom);
      4:       ts = 24'($urandom_range(24'h08_0000, 24'h40_0000));
      default: ts = TickMultReset;
    endcase
    reg_write(REG_TICK_MULT, ts);
    if ($urandom_range(0, 2) == 0) begin
      reg_write(CfgIdxW'($urandom_range(5, 7)), CfgDataW'($urandom));
    end
  endtask

  // Mostly steady tick advances; some repeats, long jumps and wraps
  task automatic queue_random(input int count);
    int          k;
    logic        op;
    logic [31:0] stamp;
    logic [15:0] meas;
    for (k = 0; k < count; k++) begin
      op = ($urandom_range(0, 99) < 65) ? OP_STEP : OP_RECORD;
      case ($urandom_range(0, 15))
        0:       stamp = $urandom;
        1:       stamp = 32'hFFFF_FF00 | $urandom_range(0, 255);
        2, 3:    stamp = gen_stamp;
        4:       stamp = gen_stamp + $urandom_range(1, 32'h00FF_FFFF);
        default: stamp = gen_stamp + $urandom_range(1, 2000);
      endcase
      case ($urandom_range(0, 7))
        0:       meas = 16'h8000;
        1:       meas = 16'h7FFF;
        2, 3:    meas = 16'(target_q + $urandom_range(0, 64) - 32);
        default: meas = 16'($urandom);
      endcase
      queue_item(op, stamp, meas);
    end
  endtask

  initial begin
    int ph;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // nominal gains: first step from reset, repeated stamp, wrap, huge dt both ways
    reg_write(REG_GAIN_PROP, 24'h00_0100);
    reg_write(REG_GAIN_INTEG, 24'h00_0010);
    reg_write(REG_GAIN_DERIV, 24'h00_0200);
    reg_write(REG_TARGET_VALUE, 24'd1000);
    reg_write(REG_TICK_MULT, TickMultReset);
    queue_item(OP_STEP,   32'd100,       16'd0);
    queue_item(OP_RECORD, 32'd200,       16'h7FFF);
    queue_item(OP_STEP,   32'd200,       16'd500);
    queue_item(OP_STEP,   32'd300,       16'h8000);
    queue_item(OP_STEP,   32'd400,       16'h7FFF);
    queue_item(OP_RECORD, 32'hFFFF_FFF0, 16'hFFFF);
    queue_item(OP_STEP,   32'h0000_0010, 16'd1000);
    queue_item(OP_STEP,   32'h8000_0010, 16'h8000);
    queue_item(OP_STEP,   32'h0000_0010, 16'h7FFF);
    queue_item(OP_STEP,   32'hFFFF_FFFF, 16'd0);
    settle();

    // most negative P and D gains and setpoint, largest I gain and time scale, ignored indexes
    reg_write(REG_GAIN_PROP, 24'hFF_8000);
    reg_write(REG_GAIN_INTEG, 24'h00_7FFF);
    reg_write(REG_GAIN_DERIV, 24'hAA_8000);
    reg_write(REG_TARGET_VALUE, 24'h00_8000);
    reg_write(REG_TICK_MULT, 24'hFF_FFFF);
    reg_write(CfgIdxW'(5), 24'hFF_FFFF);
    reg_write(CfgIdxW'(6), 24'h55_5555);
    reg_write(CfgIdxW'(7), 24'hAA_AAAA);
    queue_item(OP_STEP,   32'd0,         16'h7FFF);
    queue_item(OP_STEP,   32'hFFFF_FFFF, 16'h8000);
    queue_item(OP_STEP,   32'hFFFF_FFFF, 16'h7FFF);
    queue_item(OP_RECORD, 32'd0,         16'd0);
    queue_item(OP_STEP,   32'd1,         16'h8000);
    queue_item(OP_STEP,   32'd2,         16'd0);
    settle();

    // zero time scale: every step skips the derivative
    reg_write(REG_GAIN_PROP, 24'h00_7FFF);
    reg_write(REG_GAIN_INTEG, 24'h00_8000);
    reg_write(REG_GAIN_DERIV, 24'h00_7FFF);
    reg_write(REG_TARGET_VALUE, 24'h00_7FFF);
    reg_write(REG_TICK_MULT, 24'h00_0000);
    queue_item(OP_STEP,   32'd10,        16'h8000);
    queue_item(OP_STEP,   32'd20,        16'h7FFF);
    queue_item(OP_STEP,   32'h1234_5678, 16'd0);
    queue_item(OP_RECORD, 32'd5,         16'd5);
    queue_item(OP_STEP,   32'd5,         16'hFFFF);
    settle();

    // smallest nonzero time scale: a step with scaled dt of one has no integral step and divides by one
    reg_write(REG_GAIN_PROP, 24'h00_0001);
    reg_write(REG_GAIN_INTEG, 24'h00_0001);
    reg_write(REG_GAIN_DERIV, 24'h00_7FFF);
    reg_write(REG_TARGET_VALUE, 24'h00_0000);
    reg_write(REG_TICK_MULT, 24'h00_0001);
    queue_item(OP_STEP, 32'd1,         16'd1);
    queue_item(OP_STEP, 32'd2,         16'h8000);
    queue_item(OP_STEP, 32'h0000_1002, 16'h7FFF);
    settle();

    // random phases, each with its own register setting
    for (ph = 0; ph < 8; ph++) begin
      draw_setup();
      queue_random(212);
      settle();
    end

    if (mismatch_count == 0 && drive_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(20_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
